FILE: rtl/core/assert_macros.svh
// Assertion shorthands used by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: check failed");

`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

`endif

FILE: rtl/core/lrsf_pkg.sv
package lrsf_pkg;

    localparam int ROOT_W   = 16;
    localparam int FREQ_W   = 21;
    localparam int BW_W     = 24;
    localparam int RATE_W   = 18;
    localparam int MARGIN_W = 17;
    localparam int CFG_W    = 18;

    localparam int CORDIC_STEPS = 24;

    localparam logic [31:0]          PI_Q30          = 32'd3373259426;
    localparam logic [29:0]          LN2_OVER_PI_Q32 = 30'd947622687;
    localparam logic signed [BW_W-1:0] BW_MAX        = 24'sd8388607;
    // Floor of 2^53 / PI_Q30; gives a frequency quotient at most two below the true one.
    localparam logic [21:0]          RECIP_PI        = 22'd2670176;

    typedef enum logic [0:0] {
        CFG_SAMPLE_RATE = 1'b0,
        CFG_MARGIN      = 1'b1
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_CORDIC,
        ST_ANGLE,
        ST_DIVLOG,
        ST_LOGMUL,
        ST_BWMUL,
        ST_END,
        ST_SCAN,
        ST_PUSH,
        ST_SWAP_LO,
        ST_SWAP_HI,
        ST_EMPTY
    } state_t;

    // Arctangent of 2^-idx in Q0.30, truncated.
    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] v;
        begin
            unique case (idx)
                5'd0:  v = 30'd843314856;
                5'd1:  v = 30'd497837829;
                5'd2:  v = 30'd263043836;
                5'd3:  v = 30'd133525158;
                5'd4:  v = 30'd67021686;
                5'd5:  v = 30'd33543515;
                5'd6:  v = 30'd16775850;
                5'd7:  v = 30'd8388437;
                5'd8:  v = 30'd4194282;
                5'd9:  v = 30'd2097149;
                5'd10: v = 30'd1048575;
                5'd11: v = 30'd524287;
                5'd12: v = 30'd262143;
                5'd13: v = 30'd131071;
                5'd14: v = 30'd65535;
                5'd15: v = 30'd32767;
                5'd16: v = 30'd16383;
                5'd17: v = 30'd8191;
                5'd18: v = 30'd4095;
                5'd19: v = 30'd2047;
                5'd20: v = 30'd1023;
                5'd21: v = 30'd511;
                5'd22: v = 30'd255;
                5'd23: v = 30'd127;
                default: v = 30'd0;
            endcase
            return v;
        end
    endfunction

endpackage

FILE: rtl/core/lpc_roots_to_sorted_formants_top.sv
// The block takes no new root until it is done with the last one (a root with a negative
// imaginary part goes straight to the end state): the 24-step CORDIC and the 24-step logarithm loop set the work.
// On the last root the formants are sorted in place in the store: each pass scans the memory
// for the smallest frequency, outputs it and swaps it into place if needed, one word each pass.
// Reset clears the control state, the counters and the configuration to 10000 Hz and 50 Hz.
// The formant store is not cleared; only entries written in the current frame are read.
`include "assert_macros.svh"

module lpc_roots_to_sorted_formants_top
    import lrsf_pkg::*;
#(
    parameter int MAX_FORMANTS = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [0:0]               cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [ROOT_W-1:0] root_real,
    input  logic signed [ROOT_W-1:0] root_imag,
    input  logic                     last_root,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [FREQ_W-1:0]        frequency_q4,
    output logic signed [BW_W-1:0]   bandwidth_q4,
    output logic                     empty_frame,
    output logic                     overflow,
    output logic                     last_formant
);

    localparam int AW = $clog2(MAX_FORMANTS);
    localparam int CW = $clog2(MAX_FORMANTS + 1);

    state_t state_reg, state_next;

    logic [RATE_W-1:0]   rate_reg;
    logic [MARGIN_W-1:0] margin_reg;

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [4:0]    it_reg, it_next;
    logic [AW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic          pend_reg, pend_next;
    logic          first_reg, first_next;
    logic          out_valid_reg, out_valid_next;

    logic signed [ROOT_W-1:0] re_reg, re_next;
    logic signed [ROOT_W-1:0] im_reg, im_next;
    logic                     last_reg, last_next;
    logic signed [33:0]       x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [31:0]              nm_reg, nm_next;
    logic [4:0]               ne_reg, ne_next;
    logic                     r2_zero_reg, r2_zero_next;
    logic [52:0]              rem_reg, rem_next;
    logic [FREQ_W-1:0]        lo_reg, lo_next;
    logic [30:0]              m_reg, m_next;
    logic [23:0]              frac_reg, frac_next;
    logic [34:0]              u_reg, u_next;
    logic                     lpos_reg, lpos_next;
    logic                     keep_reg, keep_next;
    logic [FREQ_W-1:0]        f_reg, f_next;
    logic [AW-1:0]            pidx_reg, pidx_next;
    logic [FREQ_W-1:0]        min_f_reg, min_f_next, cur_f_reg, cur_f_next;
    logic signed [BW_W-1:0]   min_b_reg, min_b_next, cur_b_reg, cur_b_next;
    logic [AW-1:0]            min_idx_reg, min_idx_next;

    logic [FREQ_W-1:0]        of_reg, of_next;
    logic signed [BW_W-1:0]   ob_reg, ob_next;
    logic                     oe_reg, oe_next, oo_reg, oo_next, ol_reg, ol_next;

    logic [FREQ_W-1:0]      freq_mem [MAX_FORMANTS];
    logic signed [BW_W-1:0] bw_mem [MAX_FORMANTS];
    logic [FREQ_W-1:0]      rd_f_reg;
    logic signed [BW_W-1:0] rd_b_reg;
    logic                   mem_we;
    logic [AW-1:0]          mem_wa;
    logic [FREQ_W-1:0]      mem_wf;
    logic signed [BW_W-1:0] mem_wb;

    logic [FREQ_W-1:0]   fs8;
    logic [FREQ_W-1:0]   lo_band;
    logic                out_free;
    logic                in_acc;
    logic [16:0]         re_abs;
    logic signed [31:0]  sq_re, sq_im;
    logic [31:0]         r2;
    logic signed [33:0]  dx, dy, atan_ext;
    logic [4:0]          sh;
    logic                top_zero;
    logic signed [33:0]  pi34, a_raw;
    logic [31:0]         angle;
    logic [52:0]         prod;
    logic [53:0]         qprod;
    logic [52:0]         qpi;
    logic                rem_ge;
    logic [61:0]         msq;
    logic [31:0]         sq;
    logic signed [6:0]   lexp;
    logic signed [30:0]  lval;
    logic [30:0]         lmag;
    logic [58:0]         uprod;
    logic [56:0]         dprod;
    logic [24:0]         dval, dneg_sat;
    logic signed [BW_W-1:0] bw_val;
    logic                scan_issue;
    logic                last_of_frame;

    assign fs8      = {rate_reg, 3'b000};
    assign lo_band  = {margin_reg, 4'b0000};
    assign out_free = !out_valid_reg || !out_stall;
    assign in_acc   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);

    assign out_valid    = out_valid_reg;
    assign frequency_q4 = of_reg;
    assign bandwidth_q4 = ob_reg;
    assign empty_frame  = oe_reg;
    assign overflow     = oo_reg;
    assign last_formant = ol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rate_reg      <= RATE_W'(10000);
            margin_reg    <= MARGIN_W'(50);
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            it_reg        <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            pend_reg      <= 1'b0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            it_reg        <= it_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            pend_reg      <= pend_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                if (cfg_index == CFG_SAMPLE_RATE)
                begin
                    rate_reg <= cfg_data[RATE_W-1:0];
                end
                else
                begin
                    margin_reg <= cfg_data[MARGIN_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        re_reg      <= re_next;
        im_reg      <= im_next;
        last_reg    <= last_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        z_reg       <= z_next;
        nm_reg      <= nm_next;
        ne_reg      <= ne_next;
        r2_zero_reg <= r2_zero_next;
        rem_reg     <= rem_next;
        lo_reg      <= lo_next;
        m_reg       <= m_next;
        frac_reg    <= frac_next;
        u_reg       <= u_next;
        lpos_reg    <= lpos_next;
        keep_reg    <= keep_next;
        f_reg       <= f_next;
        pidx_reg    <= pidx_next;
        min_f_reg   <= min_f_next;
        min_b_reg   <= min_b_next;
        cur_f_reg   <= cur_f_next;
        cur_b_reg   <= cur_b_next;
        min_idx_reg <= min_idx_next;
        of_reg      <= of_next;
        ob_reg      <= ob_next;
        oe_reg      <= oe_next;
        oo_reg      <= oo_next;
        ol_reg      <= ol_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            freq_mem[mem_wa] <= mem_wf;
            bw_mem[mem_wa]   <= mem_wb;
        end
        rd_f_reg <= freq_mem[j_reg[AW-1:0]];
        rd_b_reg <= bw_mem[j_reg[AW-1:0]];
    end

    // Datapath terms used by the state machine below.
    always_comb
    begin
        re_abs   = re_reg[ROOT_W-1] ? 17'(-{re_reg[ROOT_W-1], re_reg}) : {1'b0, re_reg};
        sq_re    = re_reg * re_reg;
        sq_im    = im_reg * im_reg;
        r2       = $unsigned(sq_re) + $unsigned(sq_im);
        dx       = y_reg >>> it_reg;
        dy       = x_reg >>> it_reg;
        atan_ext = $signed({4'b0000, atan_q30(it_reg)});
        sh       = 5'd16 >> it_reg;
        top_zero = ((nm_reg >> (6'd32 - {1'b0, sh})) == 32'd0);
        pi34     = $signed({2'b00, PI_Q30});
        a_raw    = re_reg[ROOT_W-1] ? (pi34 - z_reg) : z_reg;
        if (im_reg == '0)
        begin
            angle = re_reg[ROOT_W-1] ? PI_Q30 : 32'd0;
        end
        else if (a_raw < 0)
        begin
            angle = 32'd0;
        end
        else if (a_raw > pi34)
        begin
            angle = PI_Q30;
        end
        else
        begin
            angle = a_raw[31:0];
        end
        prod     = 53'(angle) * 53'(fs8) + 53'(PI_Q30 >> 1);
        qprod    = 54'(rem_reg[52:21]) * 54'(RECIP_PI);
        qpi      = 53'(lo_reg) * 53'(PI_Q30);
        rem_ge   = (rem_reg >= 53'(PI_Q30));
        msq      = 62'(m_reg) * 62'(m_reg);
        sq       = msq[61:30];
        lexp     = $signed({2'b00, ne_reg}) - 7'sd28;
        lval     = $signed({lexp, 24'd0}) + $signed({7'd0, frac_reg});
        lmag     = lval[30] ? 31'(-lval) : lval;
        uprod    = 59'(lmag[28:0]) * 59'(LN2_OVER_PI_Q32) + 59'(1 << 23);
        dprod    = 57'(u_reg) * 57'(fs8) + 57'(33'h080000000);
        dval     = dprod[56:32];
        dneg_sat = (dval > 25'd8388608) ? 25'd8388608 : dval;
        if (r2_zero_reg)
        begin
            bw_val = BW_MAX;
        end
        else if (!lpos_reg)
        begin
            bw_val = (dval > 25'd8388607) ? BW_MAX : $signed(dval[BW_W-1:0]);
        end
        else
        begin
            bw_val = $signed(BW_W'(-dneg_sat));
        end
        scan_issue    = (j_reg < count_reg);
        last_of_frame = ((CW'(i_reg) + CW'(1)) == count_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        it_next        = it_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        pend_next      = pend_reg;
        first_next     = first_reg;
        out_valid_next = out_valid_reg && out_stall;
        re_next        = re_reg;
        im_next        = im_reg;
        last_next      = last_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        nm_next        = nm_reg;
        ne_next        = ne_reg;
        r2_zero_next   = r2_zero_reg;
        rem_next       = rem_reg;
        lo_next        = lo_reg;
        m_next         = m_reg;
        frac_next      = frac_reg;
        u_next         = u_reg;
        lpos_next      = lpos_reg;
        keep_next      = keep_reg;
        f_next         = f_reg;
        pidx_next      = pidx_reg;
        min_f_next     = min_f_reg;
        min_b_next     = min_b_reg;
        cur_f_next     = cur_f_reg;
        cur_b_next     = cur_b_reg;
        min_idx_next   = min_idx_reg;
        of_next        = of_reg;
        ob_next        = ob_reg;
        oe_next        = oe_reg;
        oo_next        = oo_reg;
        ol_next        = ol_reg;
        mem_we         = 1'b0;
        mem_wa         = count_reg[AW-1:0];
        mem_wf         = f_reg;
        mem_wb         = bw_val;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    re_next    = root_real;
                    im_next    = root_imag;
                    last_next  = last_root;
                    state_next = root_imag[ROOT_W-1] ? ST_END : ST_PREP;
                end
            end
            ST_PREP:
            begin
                x_next       = {3'b000, re_abs, 14'd0};
                y_next       = {{4{im_reg[ROOT_W-1]}}, im_reg, 14'd0};
                z_next       = '0;
                nm_next      = r2;
                ne_next      = 5'd31;
                r2_zero_next = (r2 == 32'd0);
                it_next      = '0;
                state_next   = ST_CORDIC;
            end
            ST_CORDIC:
            begin
                if (!y_reg[33])
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + atan_ext;
                end
                else
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - atan_ext;
                end
                // The exponent search runs alongside, halving the shift each step.
                if ((it_reg < 5'd5) && top_zero)
                begin
                    nm_next = nm_reg << sh;
                    ne_next = ne_reg - sh;
                end
                if (it_reg == 5'(CORDIC_STEPS - 1))
                begin
                    state_next = ST_ANGLE;
                end
                else
                begin
                    it_next = it_reg + 5'd1;
                end
            end
            ST_ANGLE:
            begin
                rem_next   = prod;
                lo_next    = '0;
                m_next     = nm_reg[31:1];
                frac_next  = '0;
                it_next    = '0;
                state_next = ST_DIVLOG;
            end
            ST_DIVLOG:
            begin
                // The frequency quotient is estimated by a reciprocal and then corrected.
                if (it_reg == 5'd0)
                begin
                    lo_next = qprod[52:32];
                end
                else if (it_reg == 5'd1)
                begin
                    rem_next = rem_reg - qpi;
                end
                else if ((it_reg < 5'd5) && rem_ge)
                begin
                    rem_next = rem_reg - 53'(PI_Q30);
                    lo_next  = lo_reg + FREQ_W'(1);
                end
                m_next    = sq[31] ? sq[31:1] : sq[30:0];
                frac_next = {frac_reg[22:0], sq[31]};
                if (it_reg == 5'd23)
                begin
                    state_next = ST_LOGMUL;
                end
                else
                begin
                    it_next = it_reg + 5'd1;
                end
            end
            ST_LOGMUL:
            begin
                u_next     = uprod[58:24];
                lpos_next  = !lval[30] && (lval != '0);
                f_next     = lo_reg;
                keep_next  = (lo_reg >= lo_band) &&
                             (({1'b0, lo_reg} + {1'b0, lo_band}) <= {1'b0, fs8});
                state_next = ST_BWMUL;
            end
            ST_BWMUL:
            begin
                if (keep_reg)
                begin
                    if (count_reg < CW'(MAX_FORMANTS))
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                state_next = ST_END;
            end
            ST_END:
            begin
                if (!last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (count_reg == '0)
                begin
                    state_next = ST_EMPTY;
                end
                else
                begin
                    i_next     = '0;
                    j_next     = '0;
                    pend_next  = 1'b0;
                    first_next = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // One read issued per cycle; the word read last cycle is compared now.
                pend_next = scan_issue;
                pidx_next = j_reg[AW-1:0];
                if (scan_issue)
                begin
                    j_next = j_reg + CW'(1);
                end
                if (pend_reg)
                begin
                    if (first_reg)
                    begin
                        cur_f_next   = rd_f_reg;
                        cur_b_next   = rd_b_reg;
                        min_f_next   = rd_f_reg;
                        min_b_next   = rd_b_reg;
                        min_idx_next = pidx_reg;
                        first_next   = 1'b0;
                    end
                    else if (rd_f_reg < min_f_reg)
                    begin
                        min_f_next   = rd_f_reg;
                        min_b_next   = rd_b_reg;
                        min_idx_next = pidx_reg;
                    end
                end
                if (!pend_reg && !scan_issue)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    of_next        = min_f_reg;
                    ob_next        = min_b_reg;
                    oe_next        = 1'b0;
                    oo_next        = ovf_reg;
                    ol_next        = last_of_frame;
                    if (min_idx_reg != i_reg)
                    begin
                        state_next = ST_SWAP_LO;
                    end
                    else if (last_of_frame)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + AW'(1);
                        j_next     = CW'(i_reg) + CW'(1);
                        first_next = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SWAP_LO:
            begin
                mem_we     = 1'b1;
                mem_wa     = i_reg;
                mem_wf     = min_f_reg;
                mem_wb     = min_b_reg;
                state_next = ST_SWAP_HI;
            end
            ST_SWAP_HI:
            begin
                mem_we = 1'b1;
                mem_wa = min_idx_reg;
                mem_wf = cur_f_reg;
                mem_wb = cur_b_reg;
                if (last_of_frame)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    i_next     = i_reg + AW'(1);
                    j_next     = CW'(i_reg) + CW'(1);
                    first_next = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    of_next        = '0;
                    ob_next        = '0;
                    oe_next        = 1'b1;
                    oo_next        = ovf_reg;
                    ol_next        = 1'b1;
                    ovf_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(MAX_FORMANTS))
    `ASSERT_IMPLIES(a_scan_bound, state_reg == ST_SCAN, j_reg <= count_reg)
    `ASSERT_IMPLIES(a_empty_last, out_valid_reg && oe_reg, ol_reg)
    `ASSERT_IMPLIES(a_swap_range, state_reg == ST_SWAP_HI, CW'(min_idx_reg) < count_reg && min_idx_reg != i_reg)

endmodule

FILE: dv/lrsf_formant_checker.sv
module lrsf_formant_checker
    import lrsf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [0:0]               cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic signed [ROOT_W-1:0] root_real,
    input  logic signed [ROOT_W-1:0] root_imag,
    input  logic                     last_root,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic [FREQ_W-1:0]        frequency_q4,
    input  logic signed [BW_W-1:0]   bandwidth_q4,
    input  logic                     empty_frame,
    input  logic                     overflow,
    input  logic                     last_formant,
    output int                       mismatch_count,
    output int                       formants_pending,
    output int                       formants_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = 32;
    localparam longint PI_ANGLE = 64'sd3373259426;
    localparam longint unsigned LN2_PI = 64'd947622687;

    typedef struct packed {
        logic [FREQ_W-1:0]      freq;
        logic signed [BW_W-1:0] bw;
        logic                   empty;
        logic                   ovf;
        logic                   last;
    } formant_t;

    localparam longint ATAN_TAB [24] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
        65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127
    };

    formant_t          expected_formants[$];
    logic [RATE_W-1:0]   rate_hz;
    logic [MARGIN_W-1:0] margin;
    logic [FREQ_W-1:0]   freq_store [STORE_DEPTH];
    logic signed [BW_W-1:0] bw_store [STORE_DEPTH];
    int                  kept;
    logic                dropped;

    function automatic longint root_angle(int re, int im);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint a;
        if (im == 0)
            return (re < 0) ? PI_ANGLE : 64'sd0;
        x = longint'((re < 0) ? -re : re) * 16384;
        y = longint'(im) * 16384;
        z = 0;
        for (int i = 0; i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_TAB[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_TAB[i];
            end
        end
        a = (re < 0) ? PI_ANGLE - z : z;
        if (a < 0)
            a = 0;
        if (a > PI_ANGLE)
            a = PI_ANGLE;
        return a;
    endfunction

    function automatic int root_bandwidth(int re, int im, longint unsigned fs8);
        longint unsigned r2;
        longint unsigned m;
        longint unsigned frac;
        longint unsigned mag;
        longint unsigned u;
        longint unsigned d;
        longint l;
        int e;
        r2 = longint'(re) * longint'(re) + longint'(im) * longint'(im);
        if (r2 == 0)
            return 8388607;
        e = 0;
        while ((r2 >> (e + 1)) != 0)
            e++;
        m = r2 << (30 - e);
        frac = 0;
        for (int i = 0; i < 24; i++)
        begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31))
            begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        l = (longint'(e) - 28) * (64'sd1 << 24) + longint'(frac);
        if (l < 0)
            mag = longint'(-l);
        else
            mag = longint'(l);
        u = (mag * LN2_PI + (64'd1 << 23)) >> 24;
        d = (u * fs8 + (64'd1 << 31)) >> 32;
        if (l <= 0)
            return (d > 64'd8388607) ? 8388607 : int'(d);
        return (d > 64'd8388608) ? -8388608 : -int'(d);
    endfunction

    task automatic take_root(int re, int im, logic is_last);
        longint unsigned fs8;
        longint unsigned f;
        longint lo;
        longint hi;
        formant_t item;
        int imin;
        logic [FREQ_W-1:0] tf;
        logic signed [BW_W-1:0] tb;
        fs8 = longint'(rate_hz) * 8;
        if (im >= 0)
        begin
            f = (longint'(root_angle(re, im)) * fs8 + 64'd1686629713) / 64'd3373259426;
            lo = longint'(margin) * 16;
            hi = longint'(fs8) - lo;
            if (longint'(f) >= lo && longint'(f) <= hi)
            begin
                if (kept < STORE_DEPTH)
                begin
                    freq_store[kept] = f[FREQ_W-1:0];
                    bw_store[kept] = BW_W'(root_bandwidth(re, im, fs8));
                    kept++;
                end
                else
                    dropped = 1'b1;
            end
        end
        if (!is_last)
            return;
        if (kept == 0)
        begin
            item = '{freq: '0, bw: '0, empty: 1'b1, ovf: dropped, last: 1'b1};
            expected_formants.push_back(item);
        end
        else
        begin
            for (int i = 0; i + 1 < kept; i++)
            begin
                imin = i;
                for (int j = i + 1; j < kept; j++)
                    if (freq_store[j] < freq_store[imin])
                        imin = j;
                if (imin != i)
                begin
                    tf = freq_store[i];
                    tb = bw_store[i];
                    freq_store[i] = freq_store[imin];
                    bw_store[i] = bw_store[imin];
                    freq_store[imin] = tf;
                    bw_store[imin] = tb;
                end
            end
            for (int i = 0; i < kept; i++)
            begin
                item = '{freq: freq_store[i], bw: bw_store[i], empty: 1'b0,
                         ovf: dropped, last: (i + 1 == kept)};
                expected_formants.push_back(item);
            end
        end
        kept = 0;
        dropped = 1'b0;
    endtask

    task automatic check_formant();
        formant_t want;
        if (expected_formants.size() == 0)
        begin
            $error("unexpected formant word: freq %0d bw %0d", frequency_q4, bandwidth_q4);
            mismatch_count++;
            return;
        end
        want = expected_formants.pop_front();
        if (frequency_q4 !== want.freq)
        begin
            $error("frequency_q4 expected %0d actual %0d", want.freq, frequency_q4);
            mismatch_count++;
        end
        if (bandwidth_q4 !== want.bw)
        begin
            $error("bandwidth_q4 expected %0d actual %0d", want.bw, bandwidth_q4);
            mismatch_count++;
        end
        if (empty_frame !== want.empty)
        begin
            $error("empty_frame expected %0d actual %0d", want.empty, empty_frame);
            mismatch_count++;
        end
        if (overflow !== want.ovf)
        begin
            $error("overflow expected %0d actual %0d", want.ovf, overflow);
            mismatch_count++;
        end
        if (last_formant !== want.last)
        begin
            $error("last_formant expected %0d actual %0d", want.last, last_formant);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_hz = 18'd10000;
            margin = 17'd50;
            kept = 0;
            dropped = 1'b0;
            mismatch_count = 0;
            formants_seen = 0;
            expected_formants.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index_t'(cfg_index) == CFG_SAMPLE_RATE)
                    rate_hz = cfg_data[RATE_W-1:0];
                else
                    margin = cfg_data[MARGIN_W-1:0];
            end
            if (out_valid && !out_stall)
            begin
                check_formant();
                formants_seen++;
            end
            if (in_valid && !in_stall)
                take_root(int'(root_real), int'(root_imag), last_root);
        end
        formants_pending = expected_formants.size();
    end
endmodule

FILE: dv/tb_lpc_roots_to_sorted_formants_top.sv
module tb_lpc_roots_to_sorted_formants_top;
    import lrsf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 4000;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [0:0]               cfg_index;
    logic [CFG_W-1:0]         cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic signed [ROOT_W-1:0] root_real;
    logic signed [ROOT_W-1:0] root_imag;
    logic                     last_root;
    logic                     out_valid;
    logic                     out_stall;
    logic [FREQ_W-1:0]        frequency_q4;
    logic signed [BW_W-1:0]   bandwidth_q4;
    logic                     empty_frame;
    logic                     overflow;
    logic                     last_formant;

    int mismatch_count;
    int formants_pending;
    int formants_seen;
    int roots_sent;
    int frames_sent;
    int settings_used;
    int idle_cycles;
    logic send_burst;
    logic recv_burst;

    lpc_roots_to_sorted_formants_top dut (.*);

    lrsf_formant_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic send_root(logic signed [ROOT_W-1:0] re, logic signed [ROOT_W-1:0] im,
                             logic is_last);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        root_real <= re;
        root_imag <= im;
        last_root <= is_last;
        do @(negedge clk); while (in_stall);
        @(posedge clk);
        roots_sent++;
        if (is_last)
            frames_sent++;
    endtask

    task automatic random_frame(int len);
        logic signed [ROOT_W-1:0] re;
        logic signed [ROOT_W-1:0] im;
        logic signed [ROOT_W-1:0] corner [5];
        int pick;
        corner = '{16'sd0, 16'sd1, -16'sd1, 16'sd32767, -16'sd32768};
        send_burst = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(0, 99);
            re = ROOT_W'($urandom());
            if (pick < 70)
                im = ROOT_W'($urandom_range(0, 32767));
            else if (pick < 85)
                im = -$signed({1'b0, 15'($urandom_range(1, 32767))});
            else
            begin
                re = corner[$urandom_range(0, 4)];
                im = corner[$urandom_range(0, 4)];
            end
            send_root(re, im, i == len - 1);
        end
    endtask

    task automatic drain_and_configure(logic [CFG_W-1:0] rate, logic [CFG_W-1:0] marg);
        in_valid <= 1'b0;
        @(negedge clk);
        while (formants_pending != 0)
            @(negedge clk);
        repeat (80) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_SAMPLE_RATE;
        cfg_data <= rate;
        @(posedge clk);
        cfg_index <= CFG_MARGIN;
        cfg_data <= marg;
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        logic [CFG_W-1:0] rates [6];
        logic [CFG_W-1:0] margins [6];
        rates = '{18'd1, 18'd192000, 18'd192000, 18'd44100, 18'd262143, 18'd8000};
        margins = '{18'd0, 18'd96000, 18'd0, 18'd100, 18'd131071, 18'd50};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_SAMPLE_RATE;
        cfg_data = '0;
        in_valid = 1'b0;
        root_real = '0;
        root_imag = '0;
        last_root = 1'b0;
        roots_sent = 0;
        frames_sent = 0;
        settings_used = 0;
        send_burst = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_root(16'sd0, 16'sd0, 1'b0);
        send_root(16'sd16384, 16'sd0, 1'b0);
        send_root(-16'sd32768, 16'sd0, 1'b0);
        send_root(16'sd32767, 16'sd32767, 1'b0);
        send_root(-16'sd32768, 16'sd32767, 1'b0);
        send_root(16'sd0, 16'sd32767, 1'b0);
        send_root(16'sd100, -16'sd5, 1'b0);
        send_root(-16'sd1, 16'sd1, 1'b0);
        send_root(16'sd8000, 16'sd8000, 1'b0);
        send_root(16'sd4000, 16'sd4000, 1'b0);
        send_root(16'sd8000, 16'sd8000, 1'b0);
        send_root(16'sd5, -16'sd100, 1'b1);
        send_root(16'sd300, -16'sd32768, 1'b1);
        send_root(16'sd16384, 16'sd0, 1'b1);
        send_root(16'sd16000, 16'sd1, 1'b1);

        for (int p = 0; p < 7; p++)
        begin
            if (p > 0)
                drain_and_configure(rates[p - 1], margins[p - 1]);
            if (p == 6)
                random_frame(36);
            while (roots_sent < 15 + 12 * (p + 1))
                random_frame($urandom_range(1, 8));
        end
        drain_and_configure(18'd10000, 18'd50);
        random_frame(35);
        in_valid <= 1'b0;
        @(negedge clk);
        while (formants_pending != 0)
            @(negedge clk);
        repeat (200) @(posedge clk);
        $display("Sent %0d roots in %0d frames over %0d rate and margin settings;",
                 roots_sent, frames_sent, settings_used + 1);
        $display("checked %0d formant words, including store overflow and empty frames.",
                 formants_seen);
        if (mismatch_count == 0 && formants_pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        int wait_cycles;
        out_stall = 1'b0;
        recv_burst = 1'b0;
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                recv_burst = ~recv_burst;
            wait_cycles = recv_burst ? 0 : $urandom_range(0, 11);
            if (wait_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(negedge clk); while (!out_valid);
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no word moved for %0d cycles.", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end
endmodule

FILE: lpc_roots_to_sorted_formants_top.f
+incdir+rtl/core
rtl/core/lrsf_pkg.sv
rtl/core/lpc_roots_to_sorted_formants_top.sv
dv/lrsf_formant_checker.sv
dv/tb_lpc_roots_to_sorted_formants_top.sv
